[design/srlp_pkg.sv]
// ----------------------------------------------------------------------------
// SMTP reply line parser package
// Shared transfer types, parser phases, status codes and character constants.
// ----------------------------------------------------------------------------
package srlp_pkg;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       reply_start;
	} byte_t;

	typedef struct packed {
		logic [9:0] smtp_code;
		logic [7:0] line_number;
		logic       final_line;
		logic [9:0] text_length;
		logic [1:0] status;
	} result_t;

	typedef enum logic [3:0] {
		PH_DIG1      = 4'd0,
		PH_DIG2      = 4'd1,
		PH_DIG3      = 4'd2,
		PH_SEP       = 4'd3,
		PH_CONT_TEXT = 4'd4,
		PH_FIN_FIRST = 4'd5,
		PH_FIN_TEXT  = 4'd6,
		PH_LF        = 4'd7,
		PH_IDLE      = 4'd8
	} phase_t;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_SYNTAX   = 2'd1;
	localparam logic [1:0] ST_MISMATCH = 2'd2;

	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_DASH  = 8'h2D;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_TWO   = 8'h32;
	localparam logic [7:0] CH_FIVE  = 8'h35;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_TILDE = 8'h7E;

endpackage

[design/srlp_core.sv]
// ----------------------------------------------------------------------------
// SMTP reply line parser core
// Holds the parser state and decides the next state and the line result for
// one byte.
// ----------------------------------------------------------------------------
module srlp_core #(
	parameter int MAX_LINES = 255,
	parameter int MAX_TEXT  = 1023
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             step,
	input  srlp_pkg::byte_t  item,
	output logic             res_valid,
	output srlp_pkg::result_t res
);
	import srlp_pkg::*;

	localparam logic [7:0] LINE_LIMIT = (MAX_LINES > 255) ? 8'd255 : 8'(MAX_LINES);
	localparam logic [9:0] TEXT_LIMIT = (MAX_TEXT > 1023) ? 10'd1023 : 10'(MAX_TEXT);

	phase_t     phase_q, phase_d, cur_phase;
	logic [9:0] code_q, code_d, cur_code;
	logic [9:0] first_q, first_d, cur_first;
	logic [7:0] lines_q, lines_d, cur_lines;
	logic [9:0] text_q, text_d, cur_text;
	logic       final_q, final_d, cur_final;

	logic [7:0] b;
	logic       is_text;
	logic       is_dig;
	logic [9:0] code_x10;
	logic [9:0] code_next;
	logic [9:0] text_inc;
	logic [7:0] lines_inc;
	logic       fail;
	logic       code_known;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_DIG1;
			code_q  <= '0;
			first_q <= '0;
			lines_q <= '0;
			text_q  <= '0;
			final_q <= 1'b0;
		end else if (step) begin
			phase_q <= phase_d;
			code_q  <= code_d;
			first_q <= first_d;
			lines_q <= lines_d;
			text_q  <= text_d;
			final_q <= final_d;
		end
	end

	always_comb begin
		b         = item.data_byte;
		cur_phase = item.reply_start ? PH_DIG1 : phase_q;
		cur_code  = item.reply_start ? '0 : code_q;
		cur_first = item.reply_start ? '0 : first_q;
		cur_lines = item.reply_start ? '0 : lines_q;
		cur_text  = item.reply_start ? '0 : text_q;
		cur_final = item.reply_start ? 1'b0 : final_q;

		is_text   = (b == CH_TAB) || (b >= CH_SPACE && b <= CH_TILDE);
		is_dig    = (b >= CH_ZERO && b <= CH_NINE);
		code_x10  = {cur_code[6:0], 3'b000} + {cur_code[8:0], 1'b0};
		code_next = code_x10 + {6'd0, b[3:0]};
		text_inc  = (cur_text < TEXT_LIMIT) ? cur_text + 10'd1 : cur_text;
		lines_inc = (cur_lines < LINE_LIMIT) ? cur_lines + 8'd1 : cur_lines;

		phase_d    = cur_phase;
		code_d     = cur_code;
		first_d    = cur_first;
		lines_d    = cur_lines;
		text_d     = cur_text;
		final_d    = cur_final;
		fail       = 1'b0;
		code_known = 1'b1;
		res_valid  = 1'b0;
		res.smtp_code   = cur_code;
		res.line_number = cur_lines;
		res.final_line  = cur_final;
		res.text_length = cur_text;
		res.status      = ST_OK;

		unique case (cur_phase)
			PH_DIG1: begin
				code_known = 1'b0;
				if (b < CH_TWO || b > CH_FIVE) begin
					fail = 1'b1;
				end else begin
					code_d  = {6'd0, b[3:0]};
					phase_d = PH_DIG2;
				end
			end
			PH_DIG2: begin
				code_known = 1'b0;
				if (b < CH_ZERO || b > CH_FIVE) begin
					fail = 1'b1;
				end else begin
					code_d  = code_next;
					phase_d = PH_DIG3;
				end
			end
			PH_DIG3: begin
				code_known = 1'b0;
				if (!is_dig) begin
					fail = 1'b1;
				end else begin
					code_d  = code_next;
					phase_d = PH_SEP;
					if (cur_lines == 8'd0) begin
						first_d = code_next;
					end
				end
			end
			PH_SEP: begin
				if (b == CH_DASH) begin
					phase_d = PH_CONT_TEXT;
				end else if (b == CH_SPACE) begin
					final_d = 1'b1;
					phase_d = PH_FIN_FIRST;
				end else if (b == CH_CR) begin
					final_d = 1'b1;
					phase_d = PH_LF;
				end else begin
					fail = 1'b1;
				end
			end
			PH_CONT_TEXT, PH_FIN_TEXT: begin
				if (b == CH_CR) begin
					phase_d = PH_LF;
				end else if (is_text) begin
					text_d = text_inc;
				end else begin
					fail = 1'b1;
				end
			end
			PH_FIN_FIRST: begin
				if (!is_text) begin
					fail = 1'b1;
				end else begin
					text_d  = text_inc;
					phase_d = PH_FIN_TEXT;
				end
			end
			PH_LF: begin
				if (b != CH_LF) begin
					fail = 1'b1;
				end else begin
					res_valid = 1'b1;
					if (cur_lines != 8'd0 && cur_code != cur_first) begin
						res.status = ST_MISMATCH;
						phase_d    = PH_IDLE;
					end else if (cur_final) begin
						phase_d = PH_IDLE;
					end else begin
						lines_d = lines_inc;
						code_d  = '0;
						text_d  = '0;
						final_d = 1'b0;
						phase_d = PH_DIG1;
					end
				end
			end
			default: begin
				phase_d = PH_IDLE;
			end
		endcase

		if (fail) begin
			res_valid     = 1'b1;
			res.status    = ST_SYNTAX;
			res.smtp_code = code_known ? cur_code : 10'd0;
			phase_d       = PH_IDLE;
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_IDLE && !item.reply_start) |-> !res_valid)
		else $error("result produced while the parser is idle");

	assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && res.status == ST_MISMATCH) |-> (cur_lines != 8'd0))
		else $error("code mismatch reported on the first line");

	assert property (@(posedge clk) disable iff (!arst_n)
		(lines_q <= LINE_LIMIT) && (text_q <= TEXT_LIMIT))
		else $error("line or text count exceeded its limit");

endmodule

[design/smtp_reply_line_parser.sv]
// ----------------------------------------------------------------------------
// SMTP reply line parser
// Checks a server reply byte by byte and reports one result per line end or
// syntax error.
// ----------------------------------------------------------------------------
//   Channel   Signals                                  Payload
//   byte      byte_valid, byte_ready, byte_data        data_byte, reply_start
//   result    result_valid, result_ready, result_data  code, line, final, length, status
//
// One byte per cycle is accepted as long as every result is taken when offered.
// After its byte transfer, a result passes the input register, then the parser
// state step and the result register, before it is offered.
// Reset leaves the parser expecting the first code digit of a reply.
// A stalled result holds the result register; the pipeline then halts and
// input stops once the input register holds a byte.
// ----------------------------------------------------------------------------
module smtp_reply_line_parser #(
	parameter int MAX_LINES = 255,
	parameter int MAX_TEXT  = 1023
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              byte_valid,
	output logic              byte_ready,
	input  srlp_pkg::byte_t   byte_data,
	output logic              result_valid,
	input  logic              result_ready,
	output srlp_pkg::result_t result_data
);
	import srlp_pkg::*;

	logic    in_valid_s1;
	byte_t   in_s1;
	logic    res_valid_s2;
	result_t res_s2;
	logic    advance;
	logic    step;
	logic    core_valid;
	result_t core_res;

	assign advance    = !res_valid_s2 || result_ready;
	assign step       = in_valid_s1 && advance;
	assign byte_ready = !in_valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid_s1 <= 1'b0;
		end else if (byte_ready) begin
			in_valid_s1 <= byte_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (byte_ready && byte_valid) begin
			in_s1 <= byte_data;
		end
	end

	srlp_core #(
		.MAX_LINES(MAX_LINES),
		.MAX_TEXT (MAX_TEXT)
	) u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.step     (step),
		.item     (in_s1),
		.res_valid(core_valid),
		.res      (core_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_s2 <= 1'b0;
		end else if (advance) begin
			res_valid_s2 <= step && core_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (step && core_valid) begin
			res_s2 <= core_res;
		end
	end

	assign result_valid = res_valid_s2;
	assign result_data  = res_s2;

	assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid_s1 && !advance) |=> (in_valid_s1 && $stable(in_s1)))
		else $error("held input byte lost during an output stall");

	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (result_data.status == ST_OK ||
			result_data.status == ST_SYNTAX || result_data.status == ST_MISMATCH))
		else $error("unknown status code in result");

	assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result_data.status != ST_SYNTAX) |->
			(result_data.smtp_code >= 10'd200 && result_data.smtp_code <= 10'd559))
		else $error("completed line carries an out-of-range reply code");

endmodule

[dv/smtp_reply_line_parser_tb.sv]
// ----------------------------------------------------------------------------
// SMTP reply line parser testbench
// Streams directed and random server replies, byte by byte, into the parser
// with random gaps and result stalls. A byte-level parser model predicts each
// line result, and every result transfer is checked field by field in order.
// ----------------------------------------------------------------------------
module smtp_reply_line_parser_tb;

	import srlp_pkg::*;

	localparam int MAX_LINES  = 255;
	localparam int MAX_TEXT   = 1023;
	localparam int LINE_LIMIT = (MAX_LINES > 255) ? 255 : MAX_LINES;
	localparam int TEXT_LIMIT = (MAX_TEXT > 1023) ? 1023 : MAX_TEXT;
	localparam int STALL_LIMIT = 1000;
	localparam int RANDOM_BYTES = 640;

	logic    clk = 1'b0;
	logic    arst_n = 1'b0;
	logic    byte_valid = 1'b0;
	logic    byte_ready;
	byte_t   byte_data = '0;
	logic    result_valid;
	logic    result_ready = 1'b0;
	result_t result_data;

	byte_t   reply_bytes_q[$];
	result_t line_results_q[$];

	phase_t     ph = PH_DIG1;
	logic [9:0] code_acc = '0;
	logic [9:0] first_code = '0;
	logic [7:0] line_cnt = '0;
	logic [9:0] text_cnt = '0;
	logic       is_final = 1'b0;

	int  byte_xfers = 0;
	int  bytes_offered = 0;
	int  results_taken = 0;
	int  results_seen = 0;
	int  send_wait = 0;
	int  take_wait = 0;
	int  idle_cycles = 0;
	int  fail_count = 0;
	int  total_bytes;
	bit  holding = 1'b0;

	smtp_reply_line_parser #(
		.MAX_LINES(MAX_LINES),
		.MAX_TEXT (MAX_TEXT)
	) u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.byte_valid  (byte_valid),
		.byte_ready  (byte_ready),
		.byte_data   (byte_data),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.result_data (result_data)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic bit is_text(input logic [7:0] c);
		return c == CH_TAB || (c >= CH_SPACE && c <= CH_TILDE);
	endfunction

	function automatic void bump_text();
		if (text_cnt < TEXT_LIMIT) begin
			text_cnt = text_cnt + 10'd1;
		end
	endfunction

	function automatic void clear_line();
		code_acc = '0;
		text_cnt = '0;
		is_final = 1'b0;
	endfunction

	function automatic bit parse_byte(input byte_t b, output result_t r);
		logic [7:0] c;
		bit         err;
		bit         done;
		c = b.data_byte;
		err = 1'b0;
		done = 1'b0;
		r = '0;
		if (b.reply_start) begin
			ph = PH_DIG1;
			first_code = '0;
			line_cnt = '0;
			clear_line();
		end
		case (ph)
			PH_DIG1: begin
				if (c >= CH_TWO && c <= CH_FIVE) begin
					code_acc = 10'(c - CH_ZERO);
					ph = PH_DIG2;
				end else begin
					err = 1'b1;
				end
			end
			PH_DIG2: begin
				if (c >= CH_ZERO && c <= CH_FIVE) begin
					code_acc = code_acc * 10'd10 + 10'(c - CH_ZERO);
					ph = PH_DIG3;
				end else begin
					err = 1'b1;
				end
			end
			PH_DIG3: begin
				if (c >= CH_ZERO && c <= CH_NINE) begin
					code_acc = code_acc * 10'd10 + 10'(c - CH_ZERO);
					if (line_cnt == 0) begin
						first_code = code_acc;
					end
					ph = PH_SEP;
				end else begin
					err = 1'b1;
				end
			end
			PH_SEP: begin
				if (c == CH_DASH) begin
					ph = PH_CONT_TEXT;
				end else if (c == CH_SPACE) begin
					is_final = 1'b1;
					ph = PH_FIN_FIRST;
				end else if (c == CH_CR) begin
					is_final = 1'b1;
					ph = PH_LF;
				end else begin
					err = 1'b1;
				end
			end
			PH_CONT_TEXT, PH_FIN_TEXT: begin
				if (c == CH_CR) begin
					ph = PH_LF;
				end else if (is_text(c)) begin
					bump_text();
				end else begin
					err = 1'b1;
				end
			end
			PH_FIN_FIRST: begin
				if (is_text(c)) begin
					bump_text();
					ph = PH_FIN_TEXT;
				end else begin
					err = 1'b1;
				end
			end
			PH_LF: begin
				if (c != CH_LF) begin
					err = 1'b1;
				end else begin
					done = 1'b1;
					r.smtp_code = code_acc;
					r.line_number = line_cnt;
					r.final_line = is_final;
					r.text_length = text_cnt;
					if (line_cnt != 0 && code_acc != first_code) begin
						r.status = ST_MISMATCH;
						ph = PH_IDLE;
					end else begin
						r.status = ST_OK;
						if (is_final) begin
							ph = PH_IDLE;
						end else begin
							if (line_cnt < LINE_LIMIT) begin
								line_cnt = line_cnt + 8'd1;
							end
							clear_line();
							ph = PH_DIG1;
						end
					end
				end
			end
			default: begin
				ph = PH_IDLE;
			end
		endcase
		if (err) begin
			done = 1'b1;
			r.smtp_code = (ph >= PH_SEP) ? code_acc : 10'd0;
			r.line_number = line_cnt;
			r.final_line = is_final;
			r.text_length = text_cnt;
			r.status = ST_SYNTAX;
			ph = PH_IDLE;
		end
		return done;
	endfunction

	function automatic void check_field(input string what, input int want, input int got);
		if (want != got) begin
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
			fail_count++;
		end
	endfunction

	always @(posedge clk) begin : monitor
		result_t predicted;
		result_t want;
		bit      moved;
		if (arst_n) begin
			moved = 1'b0;
			if (byte_valid && byte_ready) begin
				moved = 1'b1;
				byte_xfers++;
				if (parse_byte(byte_data, predicted)) begin
					line_results_q.insert(line_results_q.size(), predicted);
				end
			end
			if (result_valid && result_ready) begin
				moved = 1'b1;
				results_taken++;
				if (line_results_q.size() == 0) begin
					$display("%0t: unexpected result, expected none, actual code %0d line %0d status %0d",
						$time, result_data.smtp_code, result_data.line_number,
						result_data.status);
					fail_count++;
				end else begin
					want = line_results_q.pop_front();
					check_field("smtp_code", want.smtp_code, result_data.smtp_code);
					check_field("line_number", want.line_number, result_data.line_number);
					check_field("final_line", want.final_line, result_data.final_line);
					check_field("text_length", want.text_length, result_data.text_length);
					check_field("status", want.status, result_data.status);
				end
			end
			if (moved) begin
				idle_cycles = 0;
			end else begin
				idle_cycles++;
				if (idle_cycles >= STALL_LIMIT) begin
					$display("smtp_reply_line_parser test failed");
					$finish;
				end
			end
		end
	end

	always @(negedge clk) begin
		if (arst_n) begin
			if (holding && byte_xfers == bytes_offered) begin
				holding = 1'b0;
			end
			if (!holding) begin
				if (send_wait != 0) begin
					send_wait--;
				end else if (reply_bytes_q.size() != 0) begin
					byte_data <= reply_bytes_q.pop_front();
					holding = 1'b1;
					bytes_offered++;
					send_wait = ((bytes_offered / 128) % 4 == 3) ? 0 : $urandom_range(0, 10);
				end
			end
			byte_valid <= holding;
		end
	end

	always @(negedge clk) begin
		if (arst_n) begin
			if (results_taken != results_seen) begin
				results_seen = results_taken;
				take_wait = ((results_taken / 16) % 4 == 2) ? 0 : $urandom_range(0, 10);
			end
			if (take_wait != 0) begin
				take_wait--;
				result_ready <= 1'b0;
			end else begin
				result_ready <= 1'b1;
			end
		end
	end

	function automatic void push_byte(input logic [7:0] d, input bit s);
		byte_t b;
		b.data_byte = d;
		b.reply_start = s;
		reply_bytes_q.insert(reply_bytes_q.size(), b);
	endfunction

	function automatic logic [9:0] rand_code();
		return 10'($urandom_range(2, 5) * 100 + $urandom_range(0, 5) * 10 + $urandom_range(0, 9));
	endfunction

	function automatic logic [7:0] text_char();
		int v;
		v = $urandom_range(0, 95);
		return (v == 95) ? CH_TAB : CH_SPACE + 8'(v);
	endfunction

	// flaw: 0 clean, 1 one byte overwritten, 2 cut short, 3 empty final text
	function automatic void add_reply(input int n_lines, input int text_min, input int text_max,
			input int mism_pct, input bit s, input int flaw);
		logic [7:0] seq[$];
		logic [9:0] code;
		logic [9:0] lc;
		int         i;
		int         k;
		int         len;
		code = rand_code();
		for (i = 0; i < n_lines; i++) begin
			lc = (i > 0 && $urandom_range(0, 99) < mism_pct) ? rand_code() : code;
			seq.insert(seq.size(), CH_ZERO + 8'(lc / 100));
			seq.insert(seq.size(), CH_ZERO + 8'((lc / 10) % 10));
			seq.insert(seq.size(), CH_ZERO + 8'(lc % 10));
			if (i < n_lines - 1) begin
				seq.insert(seq.size(), CH_DASH);
				len = $urandom_range(text_min, text_max);
				for (k = 0; k < len; k++) begin
					seq.insert(seq.size(), text_char());
				end
			end else if (flaw == 3) begin
				seq.insert(seq.size(), CH_SPACE);
			end else if ($urandom_range(0, 1) == 1) begin
				seq.insert(seq.size(), CH_SPACE);
				len = $urandom_range(1, 12);
				for (k = 0; k < len; k++) begin
					seq.insert(seq.size(), text_char());
				end
			end
			seq.insert(seq.size(), CH_CR);
			seq.insert(seq.size(), CH_LF);
		end
		if (flaw == 1) begin
			seq[$urandom_range(0, seq.size() - 1)] = 8'($urandom_range(0, 255));
		end else if (flaw == 2) begin
			len = $urandom_range(1, seq.size() - 1);
			for (k = 0; k < len; k++) begin
				void'(seq.pop_back());
			end
		end
		for (i = 0; i < seq.size(); i++) begin
			push_byte(seq[i], (i == 0) ? s : 1'b0);
		end
	endfunction

	initial begin : stimulus
		int rand_base;
		int k;
		int n;
		bit s;

		// First reply without reply_start, lowest code, bare final line.
		push_byte("2", 1'b0);
		push_byte("0", 1'b0);
		push_byte("0", 1'b0);
		push_byte(CH_CR, 1'b0);
		push_byte(CH_LF, 1'b0);
		// Highest code with a one-character final text.
		push_byte("5", 1'b1);
		push_byte("5", 1'b0);
		push_byte("9", 1'b0);
		push_byte(CH_SPACE, 1'b0);
		push_byte(CH_TILDE, 1'b0);
		push_byte(CH_CR, 1'b0);
		push_byte(CH_LF, 1'b0);
		// Bad first digit, then a byte that the idle parser ignores.
		push_byte(8'h00, 1'b1);
		push_byte(8'hFF, 1'b0);
		// A space after the code followed directly by CR.
		push_byte("3", 1'b1);
		push_byte("0", 1'b0);
		push_byte("0", 1'b0);
		push_byte(CH_SPACE, 1'b0);
		push_byte(CH_CR, 1'b0);

		// Saturation of the text count.
		add_reply(2, TEXT_LIMIT + 2, TEXT_LIMIT + 2, 0, 1'b1, 0);

		rand_base = reply_bytes_q.size();
		while (reply_bytes_q.size() - rand_base < RANDOM_BYTES) begin
			if ($urandom_range(0, 99) < 12) begin
				n = $urandom_range(1, 6);
				for (k = 0; k < n; k++) begin
					s = ($urandom_range(0, 3) == 0);
					push_byte(8'($urandom_range(0, 255)), s);
				end
			end else begin
				s = ($urandom_range(0, 9) != 0);
				add_reply($urandom_range(1, 4), 0, $urandom_range(0, 12), 5, s,
					($urandom_range(0, 99) < 70) ? 0 : $urandom_range(1, 3));
			end
		end
		total_bytes = reply_bytes_q.size();

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (byte_xfers != total_bytes || line_results_q.size() != 0) begin
			@(posedge clk);
		end
		repeat (16) @(posedge clk);
		if (fail_count == 0) begin
			$display("smtp_reply_line_parser test passed");
		end else begin
			$display("smtp_reply_line_parser test failed");
		end
		$finish;
	end

endmodule
